/* rtl/core/clt_pkg.sv */
`timescale 1ns / 1ps

package clt_pkg;

	// Line length bound; the position counter saturates below it
	localparam int MAX_LINE    = 4096;
	localparam int POS_W       = 12;
	localparam int POS_CAP_INT = (MAX_LINE - 1 > 4095) ? 4095 : MAX_LINE - 1;
	localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_INT);

	// Up to four results follow from one input byte
	localparam int MAX_RES = 5;
	localparam int CNT_W   = 3;

	// Character codes
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	typedef enum logic [2:0] {
		KIND_CHAR     = 3'd0,
		KIND_END      = 3'd1,
		KIND_UNEXP    = 3'd2,
		KIND_UNCLOSED = 3'd3,
		KIND_BADOPT   = 3'd4,
		KIND_DONE     = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		TT_NAME   = 2'd0,
		TT_FILE   = 2'd1,
		TT_OPTION = 2'd2,
		TT_QUOTED = 2'd3
	} ttype_t;

	typedef enum logic [1:0] {
		PH_SKIP = 2'd0,
		PH_NAME = 2'd1,
		PH_REST = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t           phase;
		logic             in_quotes;
		logic             option_pending;
		logic             after_space;
		logic             token_nonempty;
		logic [POS_W-1:0] quote_open_pos;
		logic [POS_W-1:0] byte_pos;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:          PH_SKIP,
		in_quotes:      1'b0,
		option_pending: 1'b0,
		after_space:    1'b1,
		token_nonempty: 1'b0,
		quote_open_pos: '0,
		byte_pos:       '0
	};

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       ch_out;
		ttype_t           token_type;
		logic [POS_W-1:0] position;
		logic             line_empty;
	} res_t;

	typedef res_t [MAX_RES-1:0] res_list_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
			(c >= "a" && c <= "z");
	endfunction

	function automatic res_t mk_res(input kind_t k, input logic [7:0] c,
		input ttype_t t, input logic [POS_W-1:0] p, input logic e);
		res_t r;
		r.kind       = k;
		r.ch_out     = c;
		r.token_type = t;
		r.position   = p;
		r.line_empty = e;
		return r;
	endfunction

endpackage

/* rtl/core/clt_step.sv */
`timescale 1ns / 1ps

module clt_step (
	input  logic [7:0]               ch,
	input  logic                     last,
	input  clt_pkg::state_t          cur,
	output clt_pkg::state_t          nxt,
	output clt_pkg::res_list_t       res,
	output logic [clt_pkg::CNT_W-1:0] n
);

	// Decode one byte against the current state, list its results
	always_comb begin
		logic [clt_pkg::POS_W-1:0] pos;
		logic                      ws;
		logic                      fname_ch;
		clt_pkg::state_t           st;
		logic [clt_pkg::CNT_W-1:0] k;
		clt_pkg::res_list_t        r;

		st       = cur;
		k        = '0;
		r        = '0;
		pos      = cur.byte_pos;
		ws       = clt_pkg::is_ws(ch);
		fname_ch = clt_pkg::is_alnum(ch) || ch == clt_pkg::CH_DOT ||
			ch == clt_pkg::CH_UNDER || ch == clt_pkg::CH_SLASH;

		// Advance the byte position, saturating
		if (cur.byte_pos < clt_pkg::POS_CAP) begin
			st.byte_pos = cur.byte_pos + 1'b1;
		end

		// Leave the leading whitespace on the first other byte
		if (st.phase == clt_pkg::PH_SKIP && !ws) begin
			st.phase = clt_pkg::PH_NAME;
		end

		if (st.phase == clt_pkg::PH_NAME) begin
			if (ws) begin
				r[k] = clt_pkg::mk_res(clt_pkg::KIND_END, 8'd0, clt_pkg::TT_NAME, '0, 1'b0);
				k = k + 1'b1;
				st.phase          = clt_pkg::PH_REST;
				st.after_space    = 1'b1;
				st.in_quotes      = 1'b0;
				st.option_pending = 1'b0;
				st.token_nonempty = 1'b0;
			end else if (clt_pkg::is_alnum(ch)) begin
				r[k] = clt_pkg::mk_res(clt_pkg::KIND_CHAR, ch, clt_pkg::TT_NAME, '0, 1'b0);
				k = k + 1'b1;
			end else begin
				r[k] = clt_pkg::mk_res(clt_pkg::KIND_UNEXP, 8'd0, clt_pkg::TT_NAME, pos, 1'b0);
				k = k + 1'b1;
			end
		end else if (st.phase == clt_pkg::PH_REST) begin
			if (ch == clt_pkg::CH_QUOTE) begin
				// Close or open a quoted string
				if (st.in_quotes) begin
					r[k] = clt_pkg::mk_res(clt_pkg::KIND_END, 8'd0,
						st.option_pending ? clt_pkg::TT_OPTION : clt_pkg::TT_QUOTED,
						'0, 1'b0);
					k = k + 1'b1;
					st.in_quotes      = 1'b0;
					st.option_pending = 1'b0;
					st.token_nonempty = 1'b0;
				end else begin
					st.quote_open_pos = pos;
					st.in_quotes      = 1'b1;
				end
				st.after_space = 1'b0;
			end else if (st.in_quotes) begin
				r[k] = clt_pkg::mk_res(clt_pkg::KIND_CHAR, ch, clt_pkg::TT_NAME, '0, 1'b0);
				k = k + 1'b1;
				st.token_nonempty = 1'b1;
			end else if (ch == clt_pkg::CH_DASH) begin
				// A dash after whitespace marks an option
				if (!st.after_space) begin
					r[k] = clt_pkg::mk_res(clt_pkg::KIND_CHAR, ch, clt_pkg::TT_NAME, '0, 1'b0);
					k = k + 1'b1;
					st.token_nonempty = 1'b1;
				end else begin
					st.option_pending = 1'b1;
					st.after_space    = 1'b0;
				end
			end else if (ws) begin
				// Empty option first, then close a pending token
				if (st.option_pending && !st.token_nonempty) begin
					r[k] = clt_pkg::mk_res(clt_pkg::KIND_BADOPT, 8'd0, clt_pkg::TT_NAME, pos, 1'b0);
					k = k + 1'b1;
					st.option_pending = 1'b0;
				end else if (!st.after_space && st.token_nonempty) begin
					r[k] = clt_pkg::mk_res(clt_pkg::KIND_END, 8'd0,
						st.option_pending ? clt_pkg::TT_OPTION : clt_pkg::TT_FILE,
						'0, 1'b0);
					k = k + 1'b1;
					st.token_nonempty = 1'b0;
					st.option_pending = 1'b0;
				end
				st.after_space = 1'b1;
			end else if (fname_ch) begin
				r[k] = clt_pkg::mk_res(clt_pkg::KIND_CHAR, ch, clt_pkg::TT_NAME, '0, 1'b0);
				k = k + 1'b1;
				st.token_nonempty = 1'b1;
				st.after_space    = 1'b0;
			end else begin
				r[k] = clt_pkg::mk_res(clt_pkg::KIND_UNEXP, 8'd0, clt_pkg::TT_NAME, pos, 1'b0);
				k = k + 1'b1;
				st.after_space = 1'b0;
			end
		end

		// Close the line: pending token, open quote, dangling option, done
		if (last) begin
			if (st.phase == clt_pkg::PH_NAME) begin
				r[k] = clt_pkg::mk_res(clt_pkg::KIND_END, 8'd0, clt_pkg::TT_NAME, '0, 1'b0);
				k = k + 1'b1;
			end else if (st.phase == clt_pkg::PH_REST) begin
				if (st.token_nonempty) begin
					r[k] = clt_pkg::mk_res(clt_pkg::KIND_END, 8'd0,
						st.option_pending ? clt_pkg::TT_OPTION : clt_pkg::TT_FILE,
						'0, 1'b0);
					k = k + 1'b1;
					st.option_pending = 1'b0;
				end
				if (st.in_quotes) begin
					r[k] = clt_pkg::mk_res(clt_pkg::KIND_UNCLOSED, 8'd0, clt_pkg::TT_NAME,
						st.quote_open_pos, 1'b0);
					k = k + 1'b1;
				end
				if (st.option_pending) begin
					r[k] = clt_pkg::mk_res(clt_pkg::KIND_BADOPT, 8'd0, clt_pkg::TT_NAME,
						pos, 1'b0);
					k = k + 1'b1;
				end
			end
			r[k] = clt_pkg::mk_res(clt_pkg::KIND_DONE, 8'd0, clt_pkg::TT_NAME, '0,
				st.phase == clt_pkg::PH_SKIP);
			k = k + 1'b1;
			st = clt_pkg::STATE_RESET;
		end

		nxt = st;
		res = r;
		n   = k;
	end

endmodule

/* rtl/core/command_line_tokenizer_core.sv */
`timescale 1ns / 1ps

// An accepted byte passes through the input register and then the result queue before its first result.
// Throughput: one byte per cycle while each byte gives at most one result and the result side is
// ready; a byte with k results holds the single result port until all k are taken (up to 4 at the end of a line).
// Reset (arst_n low, asynchronous): tokenizer state returns to the start of a line,
// the input register and result queue are emptied.
module command_line_tokenizer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  logic        s_axis_tlast,   // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] ch_out, [9:8] token_type,
	                                    // [21:10] position, [22] line_empty, rest zero
	output logic [2:0]  m_axis_tuser,   // [2:0] kind
	output logic        m_axis_tlast    // last_result
);

	logic                      v_s1;
	logic [7:0]                ch_s1;
	logic                      last_s1;
	clt_pkg::state_t           state_q;
	clt_pkg::state_t           state_nxt;
	clt_pkg::res_list_t        res_nxt;
	logic [clt_pkg::CNT_W-1:0] n_nxt;
	clt_pkg::res_list_t        buf_q;
	logic [clt_pkg::CNT_W-1:0] cnt_q;
	logic                      pop;
	logic                      load;
	logic                      s_acc;
	clt_pkg::res_t             head;

	clt_step u_step (
		.ch   (ch_s1),
		.last (last_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt),
		.n    (n_nxt)
	);

	// Handshake: the queue takes a new byte's results once it drains
	assign pop  = (cnt_q != '0) && m_axis_tready;
	assign load = v_s1 && ((cnt_q == '0) ||
		(cnt_q == clt_pkg::CNT_W'(1) && m_axis_tready));
	assign s_axis_tready = !v_s1 || load;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_acc) begin
			v_s1 <= 1'b1;
		end else if (load) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			ch_s1   <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Tokenizer state advances as a byte's results enter the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clt_pkg::STATE_RESET;
		end else if (load) begin
			state_q <= state_nxt;
		end
	end

	// Result queue count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= n_nxt;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Result queue payload: load whole, shift down on each pop
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= res_nxt;
		end else if (pop) begin
			for (int i = 0; i < clt_pkg::MAX_RES - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end

	// Drive the result port from the queue head
	assign head          = buf_q[0];
	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tlast  = (cnt_q == clt_pkg::CNT_W'(1));
	assign m_axis_tuser  = head.kind;
	assign m_axis_tdata  = {1'b0, head.line_empty, head.position, head.token_type,
		head.ch_out};

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= clt_pkg::CNT_W'(clt_pkg::MAX_RES))
		else $error("result queue count out of range");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && head.kind == clt_pkg::KIND_DONE |-> m_axis_tlast)
		else $error("line done is not the final result of its byte");

	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		load && last_s1 |=> state_q.phase == clt_pkg::PH_SKIP && state_q.byte_pos == '0)
		else $error("state not cleared after end of line");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !load |=> v_s1 && $stable(ch_s1) && $stable(last_s1))
		else $error("held byte lost while the queue was busy");
`endif

endmodule

/* tb/clt_token_checker.sv */
`timescale 1ns / 1ps

// Watches both streams of the tokenizer, predicts the result items of every
// accepted byte and compares each accepted result with the oldest prediction.
module clt_token_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          due_count,
	output int          bytes_seen,
	output int          results_seen,
	output int          lines_seen
);

	typedef struct packed {
		clt_pkg::res_t r;
		logic          fin;
	} token_item_t;

	clt_pkg::state_t scan;
	token_item_t     tokens_due[$];
	token_item_t     batch[$];
	int              misses  = 0;
	int              bytes_n = 0;
	int              res_n   = 0;
	int              lines_n = 0;

	function automatic logic blank(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic word_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	// Append one predicted result to the batch of the current byte
	function automatic void note(input clt_pkg::kind_t k, input logic [7:0] c,
		input clt_pkg::ttype_t t, input logic [clt_pkg::POS_W-1:0] p, input logic e);
		token_item_t it;
		it.r.kind       = k;
		it.r.ch_out     = c;
		it.r.token_type = t;
		it.r.position   = p;
		it.r.line_empty = e;
		it.fin          = 1'b0;
		batch.insert(batch.size(), it);
	endfunction

	// Advance the tokenizer by one byte and queue the results it causes
	function automatic void tokenize_byte(input logic [7:0] c, input logic fin);
		logic [clt_pkg::POS_W-1:0] at;
		at = scan.byte_pos;
		batch.delete();
		if (scan.byte_pos < clt_pkg::POS_CAP)
			scan.byte_pos = scan.byte_pos + 1'b1;
		if (scan.phase == clt_pkg::PH_SKIP && !blank(c))
			scan.phase = clt_pkg::PH_NAME;

		if (scan.phase == clt_pkg::PH_NAME) begin
			if (blank(c)) begin
				note(clt_pkg::KIND_END, 8'd0, clt_pkg::TT_NAME, '0, 1'b0);
				scan.phase          = clt_pkg::PH_REST;
				scan.after_space    = 1'b1;
				scan.in_quotes      = 1'b0;
				scan.option_pending = 1'b0;
				scan.token_nonempty = 1'b0;
			end else if (word_char(c)) begin
				note(clt_pkg::KIND_CHAR, c, clt_pkg::TT_NAME, '0, 1'b0);
			end else begin
				note(clt_pkg::KIND_UNEXP, 8'd0, clt_pkg::TT_NAME, at, 1'b0);
			end
		end else if (scan.phase == clt_pkg::PH_REST) begin
			if (c == clt_pkg::CH_QUOTE) begin
				// close emits the token even when empty; open only records where
				if (scan.in_quotes) begin
					note(clt_pkg::KIND_END, 8'd0,
						scan.option_pending ? clt_pkg::TT_OPTION : clt_pkg::TT_QUOTED,
						'0, 1'b0);
					scan.in_quotes      = 1'b0;
					scan.option_pending = 1'b0;
					scan.token_nonempty = 1'b0;
				end else begin
					scan.quote_open_pos = at;
					scan.in_quotes      = 1'b1;
				end
				scan.after_space = 1'b0;
			end else if (scan.in_quotes) begin
				note(clt_pkg::KIND_CHAR, c, clt_pkg::TT_NAME, '0, 1'b0);
				scan.token_nonempty = 1'b1;
			end else if (c == clt_pkg::CH_DASH) begin
				if (!scan.after_space) begin
					note(clt_pkg::KIND_CHAR, c, clt_pkg::TT_NAME, '0, 1'b0);
					scan.token_nonempty = 1'b1;
				end else begin
					scan.option_pending = 1'b1;
					scan.after_space    = 1'b0;
				end
			end else if (blank(c)) begin
				// a bare dash is checked before the empty-token skip
				if (scan.option_pending && !scan.token_nonempty) begin
					note(clt_pkg::KIND_BADOPT, 8'd0, clt_pkg::TT_NAME, at, 1'b0);
					scan.option_pending = 1'b0;
				end else if (!scan.after_space && scan.token_nonempty) begin
					note(clt_pkg::KIND_END, 8'd0,
						scan.option_pending ? clt_pkg::TT_OPTION : clt_pkg::TT_FILE,
						'0, 1'b0);
					scan.token_nonempty = 1'b0;
					scan.option_pending = 1'b0;
				end
				scan.after_space = 1'b1;
			end else if (word_char(c) || c == clt_pkg::CH_DOT || c == clt_pkg::CH_UNDER ||
				c == clt_pkg::CH_SLASH) begin
				note(clt_pkg::KIND_CHAR, c, clt_pkg::TT_NAME, '0, 1'b0);
				scan.token_nonempty = 1'b1;
				scan.after_space    = 1'b0;
			end else begin
				note(clt_pkg::KIND_UNEXP, 8'd0, clt_pkg::TT_NAME, at, 1'b0);
				scan.after_space = 1'b0;
			end
		end

		// Close out the line and return to the start state
		if (fin) begin
			if (scan.phase == clt_pkg::PH_NAME) begin
				note(clt_pkg::KIND_END, 8'd0, clt_pkg::TT_NAME, '0, 1'b0);
			end else if (scan.phase == clt_pkg::PH_REST) begin
				if (scan.token_nonempty) begin
					note(clt_pkg::KIND_END, 8'd0,
						scan.option_pending ? clt_pkg::TT_OPTION : clt_pkg::TT_FILE,
						'0, 1'b0);
					scan.option_pending = 1'b0;
				end
				if (scan.in_quotes)
					note(clt_pkg::KIND_UNCLOSED, 8'd0, clt_pkg::TT_NAME,
						scan.quote_open_pos, 1'b0);
				if (scan.option_pending)
					note(clt_pkg::KIND_BADOPT, 8'd0, clt_pkg::TT_NAME, at, 1'b0);
			end
			note(clt_pkg::KIND_DONE, 8'd0, clt_pkg::TT_NAME, '0,
				scan.phase == clt_pkg::PH_SKIP);
			scan = clt_pkg::STATE_RESET;
		end

		if (batch.size() > 0)
			batch[batch.size()-1].fin = 1'b1;
		foreach (batch[i])
			tokens_due.insert(tokens_due.size(), batch[i]);
	endfunction

	task automatic report_miss(input string what);
		misses++;
		if (misses <= 40)
			$display("%0t mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin : watch
		token_item_t want;
		if (!arst_n) begin
			scan = clt_pkg::STATE_RESET;
			tokens_due.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				tokenize_byte(s_axis_tdata, s_axis_tlast);
				bytes_n++;
				if (s_axis_tlast)
					lines_n++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				res_n++;
				if (tokens_due.size() == 0) begin
					report_miss($sformatf("result %0d arrived with nothing expected", res_n));
				end else begin
					want = tokens_due.pop_front();
					if (m_axis_tuser !== want.r.kind)
						report_miss($sformatf("result %0d kind %0d, want %0d",
							res_n, m_axis_tuser, want.r.kind));
					if (m_axis_tdata[7:0] !== want.r.ch_out)
						report_miss($sformatf("result %0d ch_out %02h, want %02h",
							res_n, m_axis_tdata[7:0], want.r.ch_out));
					if (m_axis_tdata[9:8] !== want.r.token_type)
						report_miss($sformatf("result %0d token_type %0d, want %0d",
							res_n, m_axis_tdata[9:8], want.r.token_type));
					if (m_axis_tdata[21:10] !== want.r.position)
						report_miss($sformatf("result %0d position %0d, want %0d",
							res_n, m_axis_tdata[21:10], want.r.position));
					if (m_axis_tdata[22] !== want.r.line_empty)
						report_miss($sformatf("result %0d line_empty %b, want %b",
							res_n, m_axis_tdata[22], want.r.line_empty));
					if (m_axis_tdata[23] !== 1'b0)
						report_miss($sformatf("result %0d padding bit %b, want zero",
							res_n, m_axis_tdata[23]));
					if (m_axis_tlast !== want.fin)
						report_miss($sformatf("result %0d last_result %b, want %b",
							res_n, m_axis_tlast, want.fin));
				end
			end
		end
		fail_count   <= misses;
		due_count    <= tokens_due.size();
		bytes_seen   <= bytes_n;
		results_seen <= res_n;
		lines_seen   <= lines_n;
	end

endmodule

/* tb/command_line_tokenizer_core_tb.sv */
`timescale 1ns / 1ps

module command_line_tokenizer_core_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_BYTES = 140;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PULSE
	} rx_mode_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'd0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int          fail_count;
	int          due_count;
	int          bytes_seen;
	int          results_seen;
	int          lines_seen;

	int          cycles       = 0;
	int          burst_left   = 1;
	int          random_bytes = 0;
	int          stall_cnt    = 0;
	rx_mode_t    stall_mode   = RX_OPEN;
	logic [7:0]  line_bytes[$];

	command_line_tokenizer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	clt_token_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.due_count     (due_count),
		.bytes_seen    (bytes_seen),
		.results_seen  (results_seen),
		.lines_seen    (lines_seen)
	);

	always #1 clk = ~clk;

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("command_line_tokenizer_core_tb: FAIL");
			$finish;
		end
	end

	// Stall the result side in stretches of changing style
	always @(posedge clk) begin
		if (stall_cnt == 0) begin
			stall_mode <= rx_mode_t'($urandom_range(0, 3));
			stall_cnt  <= $urandom_range(20, 80);
		end else begin
			stall_cnt <= stall_cnt - 1;
		end
		case (stall_mode)
			RX_OPEN:   m_axis_tready <= 1'b1;
			RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default:   m_axis_tready <= (stall_cnt[2:0] < 3);
		endcase
	end

	function automatic logic [7:0] pick_blank();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? 8'd32 : 8'(9 + r);
	endfunction

	function automatic logic [7:0] pick_alnum();
		int r;
		r = $urandom_range(0, 61);
		if (r < 10)
			return 8'("0") + 8'(r);
		else if (r < 36)
			return 8'("A") + 8'(r - 10);
		return 8'("a") + 8'(r - 36);
	endfunction

	function automatic logic [7:0] pick_path();
		case ($urandom_range(0, 9))
			0:       return clt_pkg::CH_DOT;
			1:       return clt_pkg::CH_UNDER;
			2:       return clt_pkg::CH_SLASH;
			default: return pick_alnum();
		endcase
	endfunction

	// Append one byte to the line being built
	task automatic add_byte(input logic [7:0] c);
		line_bytes.insert(line_bytes.size(), c);
	endtask

	// Offer one byte, wait for it to be taken, then maybe leave a gap
	task automatic send_byte(input logic [7:0] c, input logic fin);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= fin;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		end
	endtask

	task automatic send_line();
		foreach (line_bytes[i])
			send_byte(line_bytes[i], i == line_bytes.size() - 1);
		line_bytes.delete();
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	// Hold the input side until every predicted result has come out
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
	endtask

	// Mostly well-formed command lines with random content, some noise
	task automatic build_random_line();
		int n;
		int args;
		if ($urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 12);
			repeat (n) add_byte(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(0, 2);
			repeat (n) add_byte(pick_blank());
			n = $urandom_range(1, 6);
			repeat (n)
				add_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
					: pick_alnum());
			args = $urandom_range(0, 4);
			repeat (args) begin
				n = $urandom_range(1, 2);
				repeat (n) add_byte(pick_blank());
				case ($urandom_range(0, 3))
					0: begin
						n = $urandom_range(1, 5);
						repeat (n)
							add_byte(($urandom_range(0, 7) == 0) ? clt_pkg::CH_DASH
								: pick_path());
					end
					1: begin
						add_byte(clt_pkg::CH_DASH);
						n = $urandom_range(0, 4);
						repeat (n) add_byte(pick_path());
					end
					2: begin
						if ($urandom_range(0, 3) == 0)
							add_byte(clt_pkg::CH_DASH);
						add_byte(clt_pkg::CH_QUOTE);
						n = $urandom_range(0, 4);
						repeat (n)
							add_byte(($urandom_range(0, 3) == 0) ? pick_blank()
								: pick_alnum());
						if ($urandom_range(0, 7) != 0)
							add_byte(clt_pkg::CH_QUOTE);
					end
					default: add_byte(8'($urandom_range(0, 255)));
				endcase
			end
			if ($urandom_range(0, 3) == 0)
				add_byte(pick_blank());
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Whitespace only, then a name cut off by the end of the line
		push_text(" \t\n\v\f\r");
		send_line();
		push_text("z");
		send_line();
		// Every token kind, a bare dash, empty quotes and a trailing dash
		push_text("\tls!9 -al a.b_c/d x-y - \"q r\" \"\" -\"\" -");
		send_line();
		// Quote left open at the end of the line
		push_text("cat \"open");
		send_line();
		// Bytes outside ASCII and control codes
		push_text("a");
		add_byte(8'h80);
		add_byte(8'h20);
		add_byte(8'h00);
		add_byte(8'hff);
		add_byte(8'h7f);
		send_line();

		hold_until_drained();

		while (random_bytes < RANDOM_BYTES) begin
			build_random_line();
			random_bytes += line_bytes.size();
			send_line();
			if ($urandom_range(0, 5) == 0)
				hold_until_drained();
		end

		hold_until_drained();
		repeat (20) @(posedge clk);

		$display("Covered %0d bytes in %0d lines and compared %0d results;", bytes_seen,
			lines_seen, results_seen);
		$display("a few hand-written lines, then %0d random bytes under mixed stalls.",
			random_bytes);
		if (fail_count == 0)
			$display("command_line_tokenizer_core_tb: PASS");
		else
			$display("command_line_tokenizer_core_tb: FAIL");
		$finish;
	end

endmodule
